// ===== rtl/nbl_pkg.sv =====
// ----------------------------------------------------------------------------
// nbl_pkg
// Shared widths, item codes and structs for the nearest box lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nbl_pkg;

  // Fixed field widths
  localparam int COORD_BITS     = 24;
  localparam int ID_BITS        = 16;
  localparam int SLOT_BITS      = 6;
  localparam int DIST_BITS      = 50;

  // Default table depth
  localparam int ROOM_SLOTS_DEF = 64;

  // Per-axis gap, its square and the two-axis sum
  localparam int GAP_BITS       = COORD_BITS;
  localparam int SQ_BITS        = 2 * GAP_BITS;
  localparam int SUM_BITS       = SQ_BITS + 1;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH    = 2;

  // Command field codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Work kinds decided by the front
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SKIP  = 2'd1,
    OP_QUERY = 2'd2
  } nbl_op_e;

  // One table entry
  typedef struct packed {
    logic                valid;
    coord_t              min_x;
    coord_t              max_x;
    coord_t              min_z;
    coord_t              max_z;
    logic [ID_BITS-1:0]  tag;
  } nbl_entry_t;

  // One queued work item
  typedef struct packed {
    nbl_op_e               op;
    logic [SLOT_BITS-1:0]  slot;
    nbl_entry_t            entry;
    coord_t                point_x;
    coord_t                point_z;
  } nbl_item_t;

  // Queue fill status
  typedef struct packed {
    logic empty;
    logic full;
  } nbl_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/nbl_front.sv =====
// ----------------------------------------------------------------------------
// nbl_front
// Accepts input beats, classifies them as load, skipped load or query and
// packs them for the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module nbl_front import nbl_pkg::*; #(
  parameter int ROOM_SLOTS = ROOM_SLOTS_DEF
) (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [SLOT_BITS-1:0]  slot_i,
  input  logic                  entry_valid_i,
  input  coord_t                min_x_i,
  input  coord_t                max_x_i,
  input  coord_t                min_z_i,
  input  coord_t                max_z_i,
  input  logic [ID_BITS-1:0]    room_tag_i,
  input  coord_t                point_x_i,
  input  coord_t                point_z_i,
  input  logic                  clearing_i,
  input  nbl_qstat_t            qstat_i,
  output logic                  push_o,
  output nbl_item_t             item_o
);

  localparam int CW  = $clog2(ROOM_SLOTS + 1);
  localparam int CMP_W = (SLOT_BITS > CW) ? SLOT_BITS : CW;

  logic in_range;

  // Hold off input during the table clear and when the queue is full
  assign in_stall_o = clearing_i || qstat_i.full;
  assign push_o     = in_valid_i && !in_stall_o;

  // Drop loads aimed past the end of the table
  assign in_range = CMP_W'(slot_i) < CMP_W'(ROOM_SLOTS);

  // Classify and pack
  always_comb begin
    if (command_i == CMD_QUERY) begin
      item_o.op = OP_QUERY;
    end else if (in_range) begin
      item_o.op = OP_LOAD;
    end else begin
      item_o.op = OP_SKIP;
    end
    item_o.slot        = slot_i;
    item_o.entry.valid = entry_valid_i;
    item_o.entry.min_x = min_x_i;
    item_o.entry.max_x = max_x_i;
    item_o.entry.min_z = min_z_i;
    item_o.entry.max_z = max_z_i;
    item_o.entry.tag   = room_tag_i;
    item_o.point_x     = point_x_i;
    item_o.point_z     = point_z_i;
  end

endmodule

`default_nettype wire

// ===== rtl/nbl_queue.sv =====
// ----------------------------------------------------------------------------
// nbl_queue
// Short first-in first-out queue of work items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nbl_queue import nbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  nbl_item_t   item_i,
  input  logic        pop_i,
  output nbl_item_t   head_o,
  output nbl_qstat_t  qstat_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  nbl_item_t         buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_o        = buf_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed beats
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nbl_back.sv =====
// ----------------------------------------------------------------------------
// nbl_back
// Holds the box table, clears it after reset, writes loads and scans the
// table for queries through a four-stage distance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module nbl_back import nbl_pkg::*; #(
  parameter int ROOM_SLOTS = ROOM_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nbl_qstat_t            qstat_i,
  input  nbl_item_t             head_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ID_BITS-1:0]    found_room_o,
  output logic                  found_o,
  output logic                  inside_res_o,
  output logic [DIST_BITS-1:0]  distance_sq_o
);

  localparam int SLOT_W = (ROOM_SLOTS > 1) ? $clog2(ROOM_SLOTS) : 1;
  localparam int SX_W   = (SLOT_BITS > SLOT_W) ? SLOT_BITS : SLOT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ROOM_SLOTS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DRAIN = 4'b1000
  } nbl_state_e;

  // Distance outside [lo, hi] along one axis, clamped at zero
  function automatic logic [GAP_BITS-1:0] axis_gap(coord_t lo, coord_t hi, coord_t p);
    logic signed [COORD_BITS:0] below;
    logic signed [COORD_BITS:0] above;
    logic signed [COORD_BITS:0] g;
    below = {lo[COORD_BITS-1], lo} - {p[COORD_BITS-1], p};
    above = {p[COORD_BITS-1], p} - {hi[COORD_BITS-1], hi};
    g = (above > below) ? above : below;
    if (g[COORD_BITS]) begin
      axis_gap = '0;
    end else begin
      axis_gap = g[GAP_BITS-1:0];
    end
  endfunction

  nbl_state_e           state_q, state_d;
  logic [SLOT_W-1:0]    addr_q, addr_d;
  logic [SX_W-1:0]      slot_ext;
  logic                 out_free;

  logic                 tbl_we;
  logic [SLOT_W-1:0]    tbl_wa;
  nbl_entry_t           tbl_wd;
  logic                 rd_en;
  logic                 start;
  logic                 res_load;
  logic                 res_scan;

  nbl_entry_t           table_q [ROOM_SLOTS];
  nbl_entry_t           rd_q;
  coord_t               point_x_q, point_z_q;

  logic                 s1_q, s2_q, s3_q;
  logic [GAP_BITS-1:0]  gx_q, gz_q;
  logic                 v2_q, v3_q;
  logic [ID_BITS-1:0]   tag2_q, tag3_q;
  logic [SQ_BITS-1:0]   sqx_q, sqz_q;
  logic [SUM_BITS-1:0]  sum;
  logic                 better;

  logic                 have_q;
  logic [SUM_BITS-1:0]  best_q;
  logic [ID_BITS-1:0]   best_tag_q;

  logic                 out_valid_q;
  logic [ID_BITS-1:0]   found_room_q;
  logic                 found_q;
  logic                 inside_q;
  logic [DIST_BITS-1:0] dist_q;

  assign slot_ext   = SX_W'(head_i.slot);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clearing_o = (state_q == ST_CLEAR);
  assign pop_o      = (state_q == ST_IDLE) && !qstat_i.empty && out_free;

  // Sequencer: clear pass, load or skip, query scan and drain
  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    tbl_we   = 1'b0;
    tbl_wa   = addr_q;
    tbl_wd   = '0;
    rd_en    = 1'b0;
    start    = 1'b0;
    res_load = 1'b0;
    res_scan = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        tbl_we = 1'b1;
        addr_d = addr_q + SLOT_W'(1);
        if (addr_q == LAST_SLOT) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          case (head_i.op)
            OP_LOAD: begin
              tbl_we   = 1'b1;
              tbl_wa   = slot_ext[SLOT_W-1:0];
              tbl_wd   = head_i.entry;
              res_load = 1'b1;
            end
            OP_QUERY: begin
              start   = 1'b1;
              addr_d  = '0;
              state_d = ST_SCAN;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_en  = 1'b1;
        addr_d = addr_q + SLOT_W'(1);
        if (addr_q == LAST_SLOT) begin
          addr_d  = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_q && !s2_q && !s3_q && out_free) begin
          res_scan = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  // Box table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      table_q[tbl_wa] <= tbl_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= table_q[addr_q];
    end
  end

  // Latch the query point
  always_ff @(posedge clk_i) begin
    if (start) begin
      point_x_q <= head_i.point_x;
      point_z_q <= head_i.point_z;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
      s3_q <= 1'b0;
    end else begin
      s1_q <= rd_en;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // Stage two: axis gaps; stage three: squares
  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      gx_q   <= axis_gap(rd_q.min_x, rd_q.max_x, point_x_q);
      gz_q   <= axis_gap(rd_q.min_z, rd_q.max_z, point_z_q);
      v2_q   <= rd_q.valid;
      tag2_q <= rd_q.tag;
    end
    if (s2_q) begin
      sqx_q  <= gx_q * gx_q;
      sqz_q  <= gz_q * gz_q;
      v3_q   <= v2_q;
      tag3_q <= tag2_q;
    end
  end

  // Stage four: sum and keep the first smallest
  assign sum    = SUM_BITS'(sqx_q) + SUM_BITS'(sqz_q);
  assign better = s3_q && v3_q && (!have_q || (sum < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (start) begin
      have_q <= 1'b0;
    end else if (better) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      best_q     <= '0;
      best_tag_q <= '0;
    end else if (better) begin
      best_q     <= sum;
      best_tag_q <= tag3_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load || res_scan) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      found_room_q <= '0;
      found_q      <= 1'b0;
      inside_q     <= 1'b0;
      dist_q       <= '0;
    end else if (res_scan) begin
      found_room_q <= best_tag_q;
      found_q      <= have_q;
      inside_q     <= have_q && (best_q == '0);
      dist_q       <= DIST_BITS'(best_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_room_o  = found_room_q;
  assign found_o       = found_q;
  assign inside_res_o  = inside_q;
  assign distance_sq_o = dist_q;

endmodule

`default_nettype wire

// ===== rtl/nearest_box_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_box_lookup_unit
// Table of boxes in the X-Z plane; loads write one slot, queries return the
// nearest valid box to a point with its squared distance.
// ----------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   input     in_valid_i / in_stall_o   command, slot, entry_valid, bounds, tag, point
//   output    out_valid_o / out_stall_i found_room, found, inside_res, distance_sq
//
// A load or an out-of-range load is answered from the idle state in the back end.
// A query scans the table: the table read port visits one
// slot per cycle, then the four-stage distance pipeline drains.
// After reset every table slot is cleared; input is stalled meanwhile.
// A two-entry queue keeps accepting input, until full, while a result waits on out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_box_lookup_unit import nbl_pkg::*; #(
  parameter int ROOM_SLOTS = ROOM_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [SLOT_BITS-1:0]  slot_i,
  input  logic                  entry_valid_i,
  input  coord_t                min_x_i,
  input  coord_t                max_x_i,
  input  coord_t                min_z_i,
  input  coord_t                max_z_i,
  input  logic [ID_BITS-1:0]    room_tag_i,
  input  coord_t                point_x_i,
  input  coord_t                point_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ID_BITS-1:0]    found_room_o,
  output logic                  found_o,
  output logic                  inside_res_o,
  output logic [DIST_BITS-1:0]  distance_sq_o
);

  logic        push;
  logic        pop;
  logic        clearing;
  nbl_item_t   item;
  nbl_item_t   head;
  nbl_qstat_t  qstat;

  // Classify input beats
  nbl_front #(
    .ROOM_SLOTS (ROOM_SLOTS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .slot_i        (slot_i),
    .entry_valid_i (entry_valid_i),
    .min_x_i       (min_x_i),
    .max_x_i       (max_x_i),
    .min_z_i       (min_z_i),
    .max_z_i       (max_z_i),
    .room_tag_i    (room_tag_i),
    .point_x_i     (point_x_i),
    .point_z_i     (point_z_i),
    .clearing_i    (clearing),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (item)
  );

  // Decouple front and back
  nbl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // Table and scan
  nbl_back #(
    .ROOM_SLOTS (ROOM_SLOTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .head_i        (head),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_room_o  (found_room_o),
    .found_o       (found_o),
    .inside_res_o  (inside_res_o),
    .distance_sq_o (distance_sq_o)
  );

`ifndef ASSERT_OFF
  // No beat enters while the table is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !(in_valid_i && !in_stall_o))
    else $error("input beat accepted during table clear");

  // Inside means a found box at zero distance, and zero distance means inside
  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (inside_res_o == (distance_sq_o == '0)))
    else $error("inside flag disagrees with distance");

  // A result without a found box carries all zeros
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |->
      (found_room_o == '0) && (distance_sq_o == '0) && !inside_res_o)
    else $error("result without a box is not all zero");
`endif

endmodule

`default_nettype wire
